/* hw/rtl/rsde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsde_pkg;

  // field widths
  localparam int unsigned READING_W = 18;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned MAG_W     = 17;

  // segment codes, bit0 = a .. bit6 = g, bit7 = decimal point
  localparam logic [SEG_W-1:0] SEG_DASH = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DP   = 8'h80;
  localparam logic [SEG_W-1:0] SEG_ZERO = 8'h3F;

  // reading limits in hundredths
  localparam logic signed [READING_W-1:0] NO_DATA_LIMIT = -18'sd9900;
  localparam logic signed [READING_W-1:0] CLAMP_LIMIT   = 18'sd99994;

  // reciprocal constants: floor(y / d) == (y * K) >> SH for all y < 2^17
  localparam logic [17:0] RECIP_10    = 18'd209716;
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam logic [17:0] RECIP_1000  = 18'd134218;
  localparam logic [17:0] RECIP_10000 = 18'd107375;

  typedef logic [SEG_W-1:0] seg_t;

  // decimal digit to seven-segment pattern
  function automatic seg_t seg_of_digit(input logic [3:0] dig);
    seg_t seg;
    unique case (dig)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/reading_to_segment_display_encoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed reading in hundredths into four seven-segment bytes
// (hundreds/sign, tens/sign, units with decimal point, tenths). Readings
// are rounded half-up to tenths, clamped at 999.9, and readings at or below
// -99.00 show four dashes with no_data set. One reading is taken every
// cycle unless in_stall is high; each result passes through the input
// register, then the conversion into the output register. The conversion
// uses four parallel constant reciprocal multiplies, which set the path
// between the two registers. A stalled output holds its result while one
// more input beat can still be taken into the input register.
module reading_to_segment_display_encoder_top
  import rsde_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  // input channel
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [READING_W-1:0] in_reading_hundredths,
  // result channel
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [SEG_W-1:0]           out_digit0_segments,
  output logic [SEG_W-1:0]           out_digit1_segments,
  output logic [SEG_W-1:0]           out_digit2_segments,
  output logic [SEG_W-1:0]           out_digit3_segments,
  output logic                       out_no_data
);

  // input register
  logic                        s1_valid_r;
  logic signed [READING_W-1:0] s1_reading_r;

  // output register
  logic       out_valid_r;
  seg_t       dig0_r, dig1_r, dig2_r, dig3_r;
  logic       no_data_r;
  seg_t       dig0_nxt, dig1_nxt, dig2_nxt, dig3_nxt;
  logic       no_data_nxt;

  logic       out_ready;
  logic       in_take;

  // conversion signals
  logic              is_neg;
  logic              clamp_hi;
  logic [MAG_W-1:0]  pos_mag;
  logic [READING_W-1:0] neg_full;
  logic [MAG_W-1:0]  y_val;
  logic [34:0]       p10, p100, p1000, p10000;
  logic [13:0]       q1;
  logic [9:0]        q2;
  logic [6:0]        q3;
  logic [3:0]        q4;
  logic [13:0]       dec_w;
  logic [9:0]        units_w;
  logic [6:0]        tens_w;
  logic              show_neg;
  logic              wide_int;

  // handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_digit0_segments = dig0_r;
  assign out_digit1_segments = dig1_r;
  assign out_digit2_segments = dig2_r;
  assign out_digit3_segments = dig3_r;
  assign out_no_data         = no_data_r;

  // magnitude with rounding offset: half-up rounding gives +5 for
  // positive readings and +4 on the magnitude of negative ones
  always_comb begin
    is_neg   = s1_reading_r[READING_W-1];
    clamp_hi = (s1_reading_r > CLAMP_LIMIT);
    pos_mag  = clamp_hi ? MAG_W'(CLAMP_LIMIT) : s1_reading_r[MAG_W-1:0];
    neg_full = -s1_reading_r;
    y_val    = is_neg ? (neg_full[MAG_W-1:0] + MAG_W'(4))
                      : (pos_mag + MAG_W'(5));
  end

  // parallel division by powers of ten
  always_comb begin
    p10    = 35'(y_val) * 35'(RECIP_10);
    p100   = 35'(y_val) * 35'(RECIP_100);
    p1000  = 35'(y_val) * 35'(RECIP_1000);
    p10000 = 35'(y_val) * 35'(RECIP_10000);
    q1     = p10[34:21];
    q2     = p100[33:24];
    q3     = p1000[33:27];
    q4     = p10000[33:30];
    dec_w   = q1 - 14'(q2) * 14'd10;
    units_w = q2 - 10'(q3) * 10'd10;
    tens_w  = q3 - 7'(q4) * 7'd10;
  end

  // digit selection
  always_comb begin
    show_neg    = is_neg && (y_val >= MAG_W'(10));
    wide_int    = (y_val >= MAG_W'(1000));
    no_data_nxt = (s1_reading_r <= NO_DATA_LIMIT);
    dig0_nxt    = SEG_ZERO;
    dig1_nxt    = SEG_ZERO;
    dig2_nxt    = seg_of_digit(units_w[3:0]) | SEG_DP;
    dig3_nxt    = seg_of_digit(dec_w[3:0]);
    if (no_data_nxt) begin
      dig0_nxt = SEG_DASH;
      dig1_nxt = SEG_DASH;
      dig2_nxt = SEG_DASH;
      dig3_nxt = SEG_DASH;
    end else if (wide_int) begin
      dig1_nxt = seg_of_digit(tens_w[3:0]);
      dig0_nxt = show_neg ? SEG_DASH : seg_of_digit(q4);
    end else if (show_neg) begin
      dig1_nxt = SEG_DASH;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (out_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_reading_r <= in_reading_hundredths;
    end
    if (out_ready && s1_valid_r) begin
      dig0_r    <= dig0_nxt;
      dig1_r    <= dig1_nxt;
      dig2_r    <= dig2_nxt;
      dig3_r    <= dig3_nxt;
      no_data_r <= no_data_nxt;
    end
  end

  // a no-data beat shows dashes everywhere
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && no_data_r) |-> (dig0_r == SEG_DASH && dig1_r == SEG_DASH &&
                                     dig2_r == SEG_DASH && dig3_r == SEG_DASH))
    else $error("no_data beat without dashes");

  // a normal beat always carries the units decimal point
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !no_data_r) |-> (dig2_r[SEG_W-1] == 1'b1))
    else $error("units digit lost its decimal point");

  // a filled input stage moves into the output register when it is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_ready) |=> out_valid_r)
    else $error("beat dropped between stages");

  // a held input stage keeps its reading
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(s1_reading_r))
    else $error("input stage changed while held");

endmodule

`default_nettype wire
